// ----- design/gcpm_pkg.sv -----
// Shared types, constants and field layout for the grid channel/pixel map.
`default_nettype none

package gcpm_pkg;

  // Default table dimensions handed to the top level.
  localparam int MAX_NODES_X_DEF = 64;
  localparam int MAX_NODES_Y_DEF = 64;

  // Field widths.
  localparam int OP_W      = 3;
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 16;
  localparam int SIZE_W    = 16;
  localparam int NODE_W    = 7;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MEM_W     = 2 * DATA_W;

  // Quantizer: the product coord * nodes and a quotient that stays below nodes.
  localparam int PROD_W    = SIZE_W + NODE_W;
  localparam int QUO_W     = NODE_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Stream layout.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 64;

  localparam int IN_X_LSB  = 0;
  localparam int IN_Y_LSB  = 6;
  localparam int IN_CH_LSB = 12;
  localparam int IN_PX_LSB = 28;
  localparam int IN_CX_LSB = 44;
  localparam int IN_CY_LSB = 60;

  localparam int OUT_CH_LSB     = 0;
  localparam int OUT_PX_LSB     = 16;
  localparam int OUT_X_LSB      = 32;
  localparam int OUT_Y_LSB      = 38;
  localparam int OUT_FOUND_BIT  = 44;
  localparam int OUT_SET_BIT    = 45;
  localparam int OUT_CNT_LSB    = 46;
  localparam int OUT_STATUS_BIT = 59;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODES_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 2'd3;

  // Reset values and special codes.
  localparam logic [NODE_W-1:0] NODES_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'hFFFF;
  localparam logic [DATA_W-1:0] UNSET_CODE  = 16'hFFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 13'h1FFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic wr_node;
    logic clr_run;
    logic div_load;
    logic div_step;
    logic q_store;
    logic axis;
    logic rd_lookup;
    logic scan_start;
    logic scan_run;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
    logic            scan_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/gcpm_ctrl.sv -----
// Controller state machine that sequences each operation through the datapath.
`default_nettype none

module gcpm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire gcpm_pkg::sts_t sts,
  output gcpm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_LOAD,
    S_DIV,
    S_QSTORE,
    S_LREAD,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          axis_r, axis_nxt;
  logic [gcpm_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.axis      = axis_r;

    unique case (state_r)
      S_INIT: begin
        // Clearing pass over the whole table after reset.
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op) inside
          gcpm_pkg::OP_WRITE: begin
            cmd.wr_node = 1'b1;
            state_nxt   = S_DONE;
          end
          gcpm_pkg::OP_LOOKUP: begin
            axis_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end
          gcpm_pkg::OP_SEARCH, gcpm_pkg::OP_COUNT: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          gcpm_pkg::OP_CLEAR: begin
            state_nxt = S_CLR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CLR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == gcpm_pkg::STEP_W'(gcpm_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_QSTORE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_QSTORE: begin
        // Store the node index of this axis, then do the other one.
        cmd.q_store = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_LREAD;
        end
      end
      S_LREAD: begin
        cmd.rd_lookup = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      axis_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/gcpm_dpath.sv -----
// Datapath: configuration, node table, quantizer divider, scan unit and result register.
`default_nettype none

module gcpm_dpath #(
  parameter int MAX_NODES_X = gcpm_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Y = gcpm_pkg::MAX_NODES_Y_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [gcpm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [gcpm_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic [gcpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [gcpm_pkg::OP_W-1:0]           in_tuser,
  input  wire gcpm_pkg::cmd_t                      cmd,
  output gcpm_pkg::sts_t                           sts,
  output logic [gcpm_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int DEPTH = MAX_NODES_X * MAX_NODES_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = gcpm_pkg::NODE_W;
  localparam int DW    = gcpm_pkg::DATA_W;
  localparam int PW    = gcpm_pkg::PROD_W;
  localparam int QW    = gcpm_pkg::QUO_W;

  // Node count in use: zero acts as one, large values saturate to the table size.
  function automatic logic [NW-1:0] eff_nodes(input logic [NW-1:0] n, input int maxn);
    logic [NW-1:0] r;
    if (n == '0) begin
      r = NW'(1);
    end else if (int'(n) > maxn) begin
      r = NW'(maxn);
    end else begin
      r = n;
    end
    return r;
  endfunction

  // Table entry of node (i, j), rows of MAX_NODES_Y entries.
  function automatic logic [AW-1:0] node_addr(input logic [NW-1:0] i, input logic [NW-1:0] j);
    return AW'(int'(i) * MAX_NODES_Y + int'(j));
  endfunction

  // Configuration registers.
  logic [NW-1:0]                  nodes_x_r, nodes_y_r;
  logic [gcpm_pkg::SIZE_W-1:0]    size_x_r, size_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_x_r <= gcpm_pkg::NODES_RESET;
      nodes_y_r <= gcpm_pkg::NODES_RESET;
      size_x_r  <= gcpm_pkg::SIZE_RESET;
      size_y_r  <= gcpm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gcpm_pkg::REG_NODES_X: nodes_x_r <= cfg_wdata[NW-1:0];
        gcpm_pkg::REG_NODES_Y: nodes_y_r <= cfg_wdata[NW-1:0];
        gcpm_pkg::REG_SIZE_X:  size_x_r  <= cfg_wdata[gcpm_pkg::SIZE_W-1:0];
        gcpm_pkg::REG_SIZE_Y:  size_y_r  <= cfg_wdata[gcpm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] nx, ny;
  assign nx = eff_nodes(nodes_x_r, MAX_NODES_X);
  assign ny = eff_nodes(nodes_y_r, MAX_NODES_Y);

  // Captured input transaction.
  logic [gcpm_pkg::OP_W-1:0]      op_r;
  logic [gcpm_pkg::IDX_W-1:0]     ix_r, iy_r;
  logic signed [DW-1:0]           ch_r, px_r;
  logic [gcpm_pkg::SIZE_W-1:0]    cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= gcpm_pkg::OP_WRITE;
    end else if (cmd.cap) begin
      op_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ix_r <= in_tdata[gcpm_pkg::IN_X_LSB +: gcpm_pkg::IDX_W];
      iy_r <= in_tdata[gcpm_pkg::IN_Y_LSB +: gcpm_pkg::IDX_W];
      ch_r <= in_tdata[gcpm_pkg::IN_CH_LSB +: DW];
      px_r <= in_tdata[gcpm_pkg::IN_PX_LSB +: DW];
      cx_r <= in_tdata[gcpm_pkg::IN_CX_LSB +: gcpm_pkg::SIZE_W];
      cy_r <= in_tdata[gcpm_pkg::IN_CY_LSB +: gcpm_pkg::SIZE_W];
    end
  end

  // Write bounds check against the node counts in use.
  logic oob;
  assign oob = ({1'b0, ix_r} >= nx) || ({1'b0, iy_r} >= ny);

  // Quantizer: coord * nodes / size by restoring division, one quotient bit per step.
  // A coordinate at or beyond the size (or a zero size) maps to the last node.
  logic [gcpm_pkg::SIZE_W-1:0] div_coord, div_size;
  logic [NW-1:0]               div_nodes;
  logic [PW-1:0]               prod;
  logic [PW-1:0]               rem_r, dsh_r;
  logic [QW-1:0]               quo_r;
  logic                        sat_r;
  logic                        div_ge;
  logic [NW-1:0]               qx_r, qy_r, q_val;

  assign div_coord = cmd.axis ? cy_r : cx_r;
  assign div_size  = cmd.axis ? size_y_r : size_x_r;
  assign div_nodes = cmd.axis ? ny : nx;
  assign prod      = PW'(div_coord) * PW'(div_nodes);
  assign div_ge    = (rem_r >= dsh_r);
  assign q_val     = sat_r ? (div_nodes - 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= prod;
      dsh_r <= PW'(div_size) << (QW - 1);
      quo_r <= '0;
      sat_r <= (div_size == '0) || (div_coord >= div_size);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QW-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_store) begin
      if (cmd.axis) begin
        qy_r <= q_val;
      end else begin
        qx_r <= q_val;
      end
    end
  end

  // Clearing pass counter; wraps to zero after the last entry.
  logic [AW-1:0] clr_addr_r;
  logic          clr_last;
  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_run) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // Scan unit: issues one read per cycle in row-major order and compares the registered read data.
  logic [NW-1:0]                si_r, sj_r, pi_r, pj_r;
  logic                         issue_v_r, pv_r;
  logic                         found_r;
  logic [NW-1:0]                hx_r, hy_r;
  logic [gcpm_pkg::CNT_W-1:0]   cnt_r;
  logic [gcpm_pkg::MEM_W-1:0]   rdata_r;
  logic [DW-1:0]                rd_ch, rd_px;
  logic                         rd_match, rd_unset, hit;

  assign rd_ch    = rdata_r[gcpm_pkg::MEM_W-1:DW];
  assign rd_px    = rdata_r[DW-1:0];
  assign rd_match = (rd_ch == ch_r) && (rd_px == px_r);
  assign rd_unset = (rd_ch == gcpm_pkg::UNSET_CODE) || (rd_px == gcpm_pkg::UNSET_CODE);
  assign hit      = pv_r && (op_r == gcpm_pkg::OP_SEARCH) && rd_match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_v_r <= 1'b0;
      pv_r      <= 1'b0;
      si_r      <= '0;
      sj_r      <= '0;
    end else if (cmd.scan_start) begin
      issue_v_r <= 1'b1;
      pv_r      <= 1'b0;
      si_r      <= '0;
      sj_r      <= '0;
    end else if (cmd.scan_run) begin
      pv_r <= issue_v_r;
      if (issue_v_r) begin
        if (sj_r == ny - 1'b1) begin
          sj_r <= '0;
          if (si_r == nx - 1'b1) begin
            issue_v_r <= 1'b0;
          end else begin
            si_r <= si_r + 1'b1;
          end
        end else begin
          sj_r <= sj_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found_r <= 1'b0;
      hx_r    <= '0;
      hy_r    <= '0;
      cnt_r   <= '0;
    end else if (cmd.scan_run) begin
      pi_r <= si_r;
      pj_r <= sj_r;
      if (hit && !found_r) begin
        found_r <= 1'b1;
        hx_r    <= pi_r;
        hy_r    <= pj_r;
      end
      if (pv_r && rd_unset && (cnt_r != gcpm_pkg::CNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Node table: one write port, one registered read port.
  logic [gcpm_pkg::MEM_W-1:0] mem [DEPTH];
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [gcpm_pkg::MEM_W-1:0] mem_wdata;

  assign mem_we    = cmd.clr_run || (cmd.wr_node && !oob);
  assign mem_waddr = cmd.clr_run ? clr_addr_r : node_addr({1'b0, ix_r}, {1'b0, iy_r});
  assign mem_wdata = cmd.clr_run ? {gcpm_pkg::UNSET_CODE, gcpm_pkg::UNSET_CODE} : {ch_r, px_r};
  assign mem_re    = cmd.rd_lookup || (cmd.scan_run && issue_v_r);
  assign mem_raddr = cmd.rd_lookup ? node_addr(qx_r, qy_r) : node_addr(si_r, sj_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Result register; fields an operation does not define stay zero.
  logic [gcpm_pkg::OUT_TDATA_W-1:0] out_nxt, out_tdata_r;

  always_comb begin
    out_nxt = '0;
    case (op_r)
      gcpm_pkg::OP_WRITE: begin
        out_nxt[gcpm_pkg::OUT_STATUS_BIT] = oob;
      end
      gcpm_pkg::OP_LOOKUP: begin
        out_nxt[gcpm_pkg::OUT_CH_LSB +: DW]             = rd_ch;
        out_nxt[gcpm_pkg::OUT_PX_LSB +: DW]             = rd_px;
        out_nxt[gcpm_pkg::OUT_X_LSB +: gcpm_pkg::IDX_W] = qx_r[gcpm_pkg::IDX_W-1:0];
        out_nxt[gcpm_pkg::OUT_Y_LSB +: gcpm_pkg::IDX_W] = qy_r[gcpm_pkg::IDX_W-1:0];
        out_nxt[gcpm_pkg::OUT_SET_BIT]                  = !rd_unset;
      end
      gcpm_pkg::OP_SEARCH: begin
        out_nxt[gcpm_pkg::OUT_X_LSB +: gcpm_pkg::IDX_W] = hx_r[gcpm_pkg::IDX_W-1:0];
        out_nxt[gcpm_pkg::OUT_Y_LSB +: gcpm_pkg::IDX_W] = hy_r[gcpm_pkg::IDX_W-1:0];
        out_nxt[gcpm_pkg::OUT_FOUND_BIT]                = found_r;
      end
      gcpm_pkg::OP_COUNT: begin
        out_nxt[gcpm_pkg::OUT_CNT_LSB +: gcpm_pkg::CNT_W] = cnt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= out_nxt;
    end
  end

  assign out_tdata     = out_tdata_r;
  assign sts.op        = op_r;
  assign sts.clr_last  = clr_last;
  assign sts.scan_done = hit || (!issue_v_r && !pv_r);

endmodule

`default_nettype wire

// ----- design/grid_channel_pixel_map.sv -----
// Top level of the grid channel/pixel map: controller plus datapath.
//
// Usage: one operation per input transaction on the in_ stream (op in in_tuser,
// node indices, channel, pixel and coordinates in in_tdata); every operation
// returns exactly one result transaction on the out_ stream. Configuration is
// written through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Items are handled one at a time; in_tready is high only while the block waits
// for a new operation. Work done between acceptance and a valid result:
//   write / unknown op: at most one table write
//   lookup: two 7-step quantizer divisions on one shared divider, one read
//   search / count: nodes_in_x * nodes_in_y entries, one table read per cycle;
//     a search stops at its first match
//   clear: all MAX_NODES_X * MAX_NODES_Y entries, one written per cycle
// The table has a single write and a single read port, which sets the scan rates.
// After reset the block runs a clearing pass over all MAX_NODES_X * MAX_NODES_Y
// entries with in_tready low; configuration writes are taken during it.
// Results sit in an output register: while the receiver stalls the block still
// takes the next operation and holds its result until the register frees up.
`default_nettype none

module grid_channel_pixel_map #(
  parameter int MAX_NODES_X = gcpm_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Y = gcpm_pkg::MAX_NODES_Y_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [gcpm_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [gcpm_pkg::CFG_W-1:0]       cfg_wdata,
  // Input stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata: node_x_in, node_y_in, channel_in, pixel_in, coord_x, coord_y, zero pad
  input  wire logic [gcpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op
  input  wire logic [gcpm_pkg::OP_W-1:0]        in_tuser,
  // Result stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata: channel_out, pixel_out, node_x_out, node_y_out, found,
  //            node_is_set, unset_count, status, zero pad
  output logic [gcpm_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  gcpm_pkg::cmd_t cmd;
  gcpm_pkg::sts_t sts;

  gcpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gcpm_dpath #(
    .MAX_NODES_X (MAX_NODES_X),
    .MAX_NODES_Y (MAX_NODES_Y)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// ----- design/gcpm_checker.sv -----
// Port-level checks for the grid channel/pixel map, bound to the top level.
`default_nettype none

module gcpm_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [gcpm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // One operation at a time: the input closes right after a transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an operation is in progress");

  // A search hit carries no count and no write status.
  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[gcpm_pkg::OUT_FOUND_BIT] |->
      (out_tdata[gcpm_pkg::OUT_CNT_LSB +: gcpm_pkg::CNT_W] == '0) &&
      !out_tdata[gcpm_pkg::OUT_STATUS_BIT])
    else $error("search result mixed with other fields");

  // Reset empties the output and closes the input for the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

endmodule

bind grid_channel_pixel_map gcpm_checker u_gcpm_checker (.*);

`default_nettype wire

// ----- tb/grid_channel_pixel_map_test.sv -----
// Self-checking testbench for the grid channel/pixel map: directed and random ops.
`default_nettype none

module grid_channel_pixel_map_test;

  localparam int GRID_X = gcpm_pkg::MAX_NODES_X_DEF;
  localparam int GRID_Y = gcpm_pkg::MAX_NODES_Y_DEF;
  localparam int TABLE_DEPTH = GRID_X * GRID_Y;

  // Op codes that the block does not define.
  localparam logic [gcpm_pkg::OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [gcpm_pkg::OP_W-1:0] OP_RESERVED_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 64;
  localparam int CONFIG_SPAN = 50;
  localparam int PAIR_POOL_MAX = 32;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic [gcpm_pkg::DATA_W-1:0] chan;
    logic [gcpm_pkg::DATA_W-1:0] pix;
    logic [gcpm_pkg::IDX_W-1:0]  node_x;
    logic [gcpm_pkg::IDX_W-1:0]  node_y;
    logic                        found;
    logic                        is_set;
    logic [gcpm_pkg::CNT_W-1:0]  unset_cnt;
    logic                        status;
  } map_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [gcpm_pkg::CFG_IDX_W-1:0]   cfg_addr;
  logic [gcpm_pkg::CFG_W-1:0]       cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  // in_tdata: node_x_in, node_y_in, channel_in, pixel_in, coord_x, coord_y, zero pad
  logic [gcpm_pkg::IN_TDATA_W-1:0]  in_tdata;
  // in_tuser: op
  logic [gcpm_pkg::OP_W-1:0]        in_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // out_tdata: channel_out, pixel_out, node_x_out, node_y_out, found,
  //            node_is_set, unset_count, status, zero pad
  logic [gcpm_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the block's tables and configuration.
  logic [gcpm_pkg::DATA_W-1:0] chan_map [TABLE_DEPTH];
  logic [gcpm_pkg::DATA_W-1:0] pix_map [TABLE_DEPTH];
  logic [gcpm_pkg::NODE_W-1:0] grid_nodes_x;
  logic [gcpm_pkg::NODE_W-1:0] grid_nodes_y;
  logic [gcpm_pkg::SIZE_W-1:0] grid_size_x;
  logic [gcpm_pkg::SIZE_W-1:0] grid_size_y;

  map_result_t                   expected_q[$];
  logic [2*gcpm_pkg::DATA_W-1:0] written_pairs[$];
  int                            mismatches = 0;
  int                            send_idle_pct = 0;
  int                            recv_stall_pct = 0;
  bit                            hold_off_req = 1'b0;
  int                            quiet_cycles = 0;

  grid_channel_pixel_map DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a period of 8 units.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_map();
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      chan_map[e] = gcpm_pkg::UNSET_CODE;
      pix_map[e] = gcpm_pkg::UNSET_CODE;
    end
  endfunction

  // A node count of zero acts as one; counts above the table size saturate.
  function automatic int eff_nodes(input logic [gcpm_pkg::NODE_W-1:0] n, input int cap_n);
    if (n == 0) return 1;
    return (n > cap_n) ? cap_n : int'(n);
  endfunction

  // floor(coord * nodes / span), clamped to the last node; span zero means last node.
  function automatic int quantize(input logic [gcpm_pkg::SIZE_W-1:0] coord, input int nodes,
                                  input logic [gcpm_pkg::SIZE_W-1:0] span);
    longint q;
    if (span == 0) return nodes - 1;
    q = (longint'(coord) * nodes) / longint'(span);
    return (q >= nodes) ? nodes - 1 : int'(q);
  endfunction

  function automatic bit node_set(input int e);
    return (chan_map[e] != gcpm_pkg::UNSET_CODE) && (pix_map[e] != gcpm_pkg::UNSET_CODE);
  endfunction

  // Applies one op to the mirror and returns the result it must produce.
  function automatic map_result_t predict_map_op(
      input logic [gcpm_pkg::OP_W-1:0] op,
      input logic [gcpm_pkg::IDX_W-1:0] x, input logic [gcpm_pkg::IDX_W-1:0] y,
      input logic [gcpm_pkg::DATA_W-1:0] ch, input logic [gcpm_pkg::DATA_W-1:0] px,
      input logic [gcpm_pkg::SIZE_W-1:0] cx, input logic [gcpm_pkg::SIZE_W-1:0] cy);
    map_result_t res;
    int nx, ny, qx, qy, e, cnt;
    bit hit;
    res = '0;
    nx = eff_nodes(grid_nodes_x, GRID_X);
    ny = eff_nodes(grid_nodes_y, GRID_Y);
    case (op)
      gcpm_pkg::OP_WRITE: begin
        if (x >= nx || y >= ny) begin
          res.status = 1'b1;
        end else begin
          e = x * GRID_Y + y;
          chan_map[e] = ch;
          pix_map[e] = px;
        end
      end
      gcpm_pkg::OP_LOOKUP: begin
        qx = quantize(cx, nx, grid_size_x);
        qy = quantize(cy, ny, grid_size_y);
        e = qx * GRID_Y + qy;
        res.chan = chan_map[e];
        res.pix = pix_map[e];
        res.node_x = gcpm_pkg::IDX_W'(qx);
        res.node_y = gcpm_pkg::IDX_W'(qy);
        res.is_set = node_set(e);
      end
      gcpm_pkg::OP_SEARCH: begin
        // Row-major walk, x outer; the first matching node wins.
        hit = 1'b0;
        for (int i = 0; i < nx && !hit; i++) begin
          for (int j = 0; j < ny && !hit; j++) begin
            e = i * GRID_Y + j;
            if (chan_map[e] == ch && pix_map[e] == px) begin
              hit = 1'b1;
              res.found = 1'b1;
              res.node_x = gcpm_pkg::IDX_W'(i);
              res.node_y = gcpm_pkg::IDX_W'(j);
            end
          end
        end
      end
      gcpm_pkg::OP_COUNT: begin
        cnt = 0;
        for (int i = 0; i < nx; i++)
          for (int j = 0; j < ny; j++)
            if (!node_set(i * GRID_Y + j)) cnt++;
        res.unset_cnt = (cnt > gcpm_pkg::CNT_MAX) ? gcpm_pkg::CNT_MAX
                                                  : gcpm_pkg::CNT_W'(cnt);
      end
      gcpm_pkg::OP_CLEAR: begin
        clear_map();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [gcpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcpm_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Writes all four registers; only called while the block is idle.
  task automatic set_config(input logic [gcpm_pkg::NODE_W-1:0] nx,
                            input logic [gcpm_pkg::NODE_W-1:0] ny,
                            input logic [gcpm_pkg::SIZE_W-1:0] sx,
                            input logic [gcpm_pkg::SIZE_W-1:0] sy);
    write_reg(gcpm_pkg::REG_NODES_X, gcpm_pkg::CFG_W'(nx));
    write_reg(gcpm_pkg::REG_NODES_Y, gcpm_pkg::CFG_W'(ny));
    write_reg(gcpm_pkg::REG_SIZE_X, gcpm_pkg::CFG_W'(sx));
    write_reg(gcpm_pkg::REG_SIZE_Y, gcpm_pkg::CFG_W'(sy));
    cfg_we <= 1'b0;
    grid_nodes_x = nx;
    grid_nodes_y = ny;
    grid_size_x = sx;
    grid_size_y = sy;
  endtask

  // Sends one op transaction; entered and left at a falling edge with
  // in_tvalid left high so that back-to-back transactions stay gapless.
  task automatic send_op(input logic [gcpm_pkg::OP_W-1:0] op,
                         input logic [gcpm_pkg::IDX_W-1:0] x,
                         input logic [gcpm_pkg::IDX_W-1:0] y,
                         input logic [gcpm_pkg::DATA_W-1:0] ch,
                         input logic [gcpm_pkg::DATA_W-1:0] px,
                         input logic [gcpm_pkg::SIZE_W-1:0] cx,
                         input logic [gcpm_pkg::SIZE_W-1:0] cy);
    logic [gcpm_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[gcpm_pkg::IN_X_LSB +: gcpm_pkg::IDX_W] = x;
    word[gcpm_pkg::IN_Y_LSB +: gcpm_pkg::IDX_W] = y;
    word[gcpm_pkg::IN_CH_LSB +: gcpm_pkg::DATA_W] = ch;
    word[gcpm_pkg::IN_PX_LSB +: gcpm_pkg::DATA_W] = px;
    word[gcpm_pkg::IN_CX_LSB +: gcpm_pkg::SIZE_W] = cx;
    word[gcpm_pkg::IN_CY_LSB +: gcpm_pkg::SIZE_W] = cy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_map_op(op, x, y, ch, px, cx, cy));
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random field generators
  // ---------------------------------------------------------------------------

  function automatic logic [gcpm_pkg::DATA_W-1:0] pick_data();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return gcpm_pkg::UNSET_CODE;
    if (roll < 70) return gcpm_pkg::DATA_W'($urandom_range(15));
    return gcpm_pkg::DATA_W'($urandom);
  endfunction

  function automatic logic [gcpm_pkg::SIZE_W-1:0] pick_coord(
      input logic [gcpm_pkg::SIZE_W-1:0] span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    if (roll < 55) return gcpm_pkg::SIZE_W'($urandom_range(span));
    return gcpm_pkg::SIZE_W'($urandom);
  endfunction

  // Mostly small grids so that searches and counts stay short.
  function automatic logic [gcpm_pkg::NODE_W-1:0] pick_small_nodes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return gcpm_pkg::NODE_W'($urandom_range(65, 127));
    return gcpm_pkg::NODE_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [gcpm_pkg::SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return gcpm_pkg::SIZE_W'(1);
    if (roll < 20) return '1;
    if (roll < 60) return gcpm_pkg::SIZE_W'($urandom_range(2, 500));
    return gcpm_pkg::SIZE_W'($urandom_range(1, 65535));
  endfunction

  // One random op; searches mostly look for pairs that were written before.
  task automatic send_random_op(input int heavy_pct, input int clear_pct);
    logic [gcpm_pkg::OP_W-1:0]     op;
    logic [gcpm_pkg::IDX_W-1:0]    x, y;
    logic [gcpm_pkg::DATA_W-1:0]   ch, px;
    logic [gcpm_pkg::SIZE_W-1:0]   cx, cy;
    logic [2*gcpm_pkg::DATA_W-1:0] pair;
    int                            roll, nx, ny;
    nx = eff_nodes(grid_nodes_x, GRID_X);
    ny = eff_nodes(grid_nodes_y, GRID_Y);
    x = ($urandom_range(99) < 85) ? gcpm_pkg::IDX_W'($urandom_range(nx - 1))
                                  : gcpm_pkg::IDX_W'($urandom);
    y = ($urandom_range(99) < 85) ? gcpm_pkg::IDX_W'($urandom_range(ny - 1))
                                  : gcpm_pkg::IDX_W'($urandom);
    ch = pick_data();
    px = pick_data();
    cx = pick_coord(grid_size_x);
    cy = pick_coord(grid_size_y);
    roll = $urandom_range(99);
    if (roll < clear_pct)
      op = gcpm_pkg::OP_CLEAR;
    else if (roll < clear_pct + 3)
      op = gcpm_pkg::OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    else if ($urandom_range(99) < heavy_pct)
      op = ($urandom_range(3) == 0) ? gcpm_pkg::OP_COUNT : gcpm_pkg::OP_SEARCH;
    else
      op = ($urandom_range(99) < 55) ? gcpm_pkg::OP_WRITE : gcpm_pkg::OP_LOOKUP;

    if (op == gcpm_pkg::OP_SEARCH) begin
      roll = $urandom_range(99);
      if (roll < 60 && written_pairs.size() != 0) begin
        pair = written_pairs[$urandom_range(written_pairs.size() - 1)];
        ch = pair[2*gcpm_pkg::DATA_W-1:gcpm_pkg::DATA_W];
        px = pair[gcpm_pkg::DATA_W-1:0];
      end else if (roll < 75) begin
        ch = gcpm_pkg::UNSET_CODE;
        px = gcpm_pkg::UNSET_CODE;
      end
    end else if (op == gcpm_pkg::OP_WRITE) begin
      written_pairs.push_back({ch, px});
      if (written_pairs.size() > PAIR_POOL_MAX) void'(written_pairs.pop_front());
    end
    send_op(op, x, y, ch, px, cx, cy);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every op on the reset configuration, with field extremes and unset patterns.
  task automatic test_ops_at_reset();
    send_op(gcpm_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    send_op(gcpm_pkg::OP_WRITE, 6'd0, 6'd0, 16'h0000, 16'h0000, '0, '0);
    send_op(gcpm_pkg::OP_WRITE, 6'd63, 6'd63, 16'h7FFF, 16'h7FFF, '1, '1);
    // Only one of the two fields unset: the node counts as unset.
    send_op(gcpm_pkg::OP_WRITE, 6'd5, 6'd7, gcpm_pkg::UNSET_CODE, 16'h0064, '0, '0);
    send_op(gcpm_pkg::OP_WRITE, 6'd6, 6'd0, 16'h1234, gcpm_pkg::UNSET_CODE, '0, '0);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'd0, 16'd0);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'd5200, 16'd7300);
    send_op(gcpm_pkg::OP_SEARCH, '0, '0, 16'h7FFF, 16'h7FFF, '0, '0);
    send_op(gcpm_pkg::OP_SEARCH, '0, '0, gcpm_pkg::UNSET_CODE, gcpm_pkg::UNSET_CODE,
            '0, '0);
    // A pair that is nowhere in the table.
    send_op(gcpm_pkg::OP_SEARCH, '0, '0, 16'h1234, 16'h5678, '0, '0);
    send_op(gcpm_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    for (int c = OP_RESERVED_LO; c <= OP_RESERVED_HI; c++)
      send_op(gcpm_pkg::OP_W'(c), '1, '1, '1, '1, '1, '1);
    send_op(gcpm_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
    send_op(gcpm_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    wait_idle();
  endtask

  // Node counts of zero and above the maximum, net sizes of zero and one,
  // and writes that fall outside the configured grid.
  task automatic test_config_corners();
    set_config(7'd0, 7'd127, 16'd0, 16'd1);
    send_op(gcpm_pkg::OP_WRITE, 6'd1, 6'd0, 16'd5, 16'd5, '0, '0);
    send_op(gcpm_pkg::OP_WRITE, 6'd0, 6'd63, 16'd5, 16'd6, '0, '0);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'd12345, 16'd0);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'd0, 16'd1);
    send_op(gcpm_pkg::OP_SEARCH, '0, '0, 16'd5, 16'd6, '0, '0);
    send_op(gcpm_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    wait_idle();
    set_config(7'd127, 7'd0, 16'd1, 16'd0);
    send_op(gcpm_pkg::OP_WRITE, 6'd10, 6'd1, 16'd9, 16'd9, '0, '0);
    send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 16'd0, 16'd999);
    send_op(gcpm_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    wait_idle();
  endtask

  // Random traffic on small grids under one idling pattern.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % CONFIG_SPAN == 0) begin
        wait_idle();
        set_config(pick_small_nodes(), pick_small_nodes(), pick_size(), pick_size());
      end
      send_random_op(30, 2);
    end
    wait_idle();
  endtask

  // Full-size grids; long scans are kept rare.
  task automatic test_large_grid(input int n_items);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    for (int k = 0; k < n_items; k++) begin
      if (k % CONFIG_SPAN == 0) begin
        wait_idle();
        if (k == 0)
          set_config(7'd64, 7'd64, 16'hFFFF, 16'hFFFF);
        else
          set_config(gcpm_pkg::NODE_W'($urandom_range(33, 127)),
                     gcpm_pkg::NODE_W'($urandom_range(33, 127)),
                     pick_size(), pick_size());
      end
      send_random_op(4, 1);
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while ops keep coming, so the
  // result register fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(7'd4, 7'd4, 16'd100, 16'd100);
    hold_off_req = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0)
        send_op(gcpm_pkg::OP_WRITE, gcpm_pkg::IDX_W'(k / 2), gcpm_pkg::IDX_W'(k % 4),
                gcpm_pkg::DATA_W'(k), gcpm_pkg::DATA_W'(k + 1), '0, '0);
      else
        send_op(gcpm_pkg::OP_LOOKUP, '0, '0, '0, '0,
                gcpm_pkg::SIZE_W'($urandom_range(99)),
                gcpm_pkg::SIZE_W'($urandom_range(99)));
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin : result_receiver
    int hold_left;
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [gcpm_pkg::DATA_W-1:0] want_v,
                             input logic [gcpm_pkg::DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    map_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.chan = out_tdata[gcpm_pkg::OUT_CH_LSB +: gcpm_pkg::DATA_W];
      got.pix = out_tdata[gcpm_pkg::OUT_PX_LSB +: gcpm_pkg::DATA_W];
      got.node_x = out_tdata[gcpm_pkg::OUT_X_LSB +: gcpm_pkg::IDX_W];
      got.node_y = out_tdata[gcpm_pkg::OUT_Y_LSB +: gcpm_pkg::IDX_W];
      got.found = out_tdata[gcpm_pkg::OUT_FOUND_BIT];
      got.is_set = out_tdata[gcpm_pkg::OUT_SET_BIT];
      got.unset_cnt = out_tdata[gcpm_pkg::OUT_CNT_LSB +: gcpm_pkg::CNT_W];
      got.status = out_tdata[gcpm_pkg::OUT_STATUS_BIT];
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %0h", $time, out_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("channel_out", want.chan, got.chan);
        check_field("pixel_out", want.pix, got.pix);
        check_field("node_x_out", gcpm_pkg::DATA_W'(want.node_x),
                    gcpm_pkg::DATA_W'(got.node_x));
        check_field("node_y_out", gcpm_pkg::DATA_W'(want.node_y),
                    gcpm_pkg::DATA_W'(got.node_y));
        check_field("found", gcpm_pkg::DATA_W'(want.found), gcpm_pkg::DATA_W'(got.found));
        check_field("node_is_set", gcpm_pkg::DATA_W'(want.is_set),
                    gcpm_pkg::DATA_W'(got.is_set));
        check_field("unset_count", gcpm_pkg::DATA_W'(want.unset_cnt),
                    gcpm_pkg::DATA_W'(got.unset_cnt));
        check_field("status", gcpm_pkg::DATA_W'(want.status),
                    gcpm_pkg::DATA_W'(got.status));
      end
    end
  end

  // Ends the run when no transaction moves on either stream for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    grid_nodes_x = gcpm_pkg::NODES_RESET;
    grid_nodes_y = gcpm_pkg::NODES_RESET;
    grid_size_x = gcpm_pkg::SIZE_RESET;
    grid_size_y = gcpm_pkg::SIZE_RESET;
    clear_map();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_ops_at_reset();
    test_config_corners();
    test_random_traffic(275, 0, 0);
    test_random_traffic(275, 67, 0);
    test_random_traffic(275, 0, 67);
    test_random_traffic(275, 8, 8);
    test_large_grid(150);
    test_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
